// File: src/dmc_pkg.sv
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared types, constants and byte-lane helpers of the cache block.
// ----------------------------------------------------------------------------
package dmc_pkg;

  localparam int ADDR_W = 14;
  localparam int WA_W = 12;
  localparam int DATA_W = 32;

  localparam int DEF_LINE_WORDS = 4;
  localparam int DEF_DATA_CACHE_WORDS = 256;
  localparam int DEF_INST_CACHE_WORDS = 256;
  localparam int DEF_MEMORY_WORDS = 4096;

  localparam logic [DATA_W-1:0] HALF_MASK = 32'h0000_FFFF;
  localparam logic [DATA_W-1:0] BYTE_MASK = 32'h0000_00FF;

  localparam logic [1:0] SIZE_WORD = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_BYTE = 2'd2;
  localparam logic [1:0] SIZE_INVALID = 2'd3;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_MISALIGNED = 2'd1;
  localparam logic [1:0] STATUS_NOT_WORD = 2'd2;

  localparam logic [1:0] REG_CACHE_ON = 2'd0;
  localparam logic [1:0] REG_UNIFIED = 2'd1;
  localparam logic [1:0] REG_THRU_MODE = 2'd2;

  typedef enum logic [1:0] {
    KIND_BYPASS,
    KIND_DATA,
    KIND_INST,
    KIND_REJECT
  } kind_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAIN,
    ST_TAG,
    ST_CMP,
    ST_EV_RD,
    ST_EV_WR,
    ST_MW_RD,
    ST_MW_WR,
    ST_FL_RD,
    ST_FL_WR,
    ST_CW_RD,
    ST_CW_ACT,
    ST_BP_RD,
    ST_BP_ACT
  } state_t;

  typedef struct packed {
    logic cache_on;
    logic unified;
    logic thru_mode;
  } cfg_t;

  typedef struct packed {
    logic              cmd;
    kind_t             kind;
    logic              use_data;
    logic              bad;
    logic [1:0]        off;
    logic [1:0]        size;
    logic [WA_W-1:0]   wa;
    logic [DATA_W-1:0] wdata;
  } item_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  function automatic int max1(input int v);
    return (v > 1) ? v : 1;
  endfunction

  function automatic logic misaligned(input logic [1:0] off, input logic [1:0] size);
    logic r;
    case (size)
      SIZE_WORD: r = (off != 2'd0);
      SIZE_HALF: r = off[0];
      SIZE_BYTE: r = 1'b0;
      default:   r = 1'b1;
    endcase
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] merge_in(input logic [DATA_W-1:0] old,
                                                 input logic [DATA_W-1:0] val,
                                                 input logic [1:0] off,
                                                 input logic [1:0] size);
    logic [4:0]        sh;
    logic [DATA_W-1:0] m;
    sh = {off, 3'b000};
    m = (size == SIZE_HALF) ? HALF_MASK : BYTE_MASK;
    if (size == SIZE_WORD) begin
      return val;
    end
    return (old & ~(m << sh)) | ((val & m) << sh);
  endfunction

  function automatic logic [DATA_W-1:0] take_out(input logic [DATA_W-1:0] w,
                                                 input logic [1:0] off,
                                                 input logic [1:0] size);
    logic [4:0]        sh;
    logic [DATA_W-1:0] r;
    sh = {off, 3'b000};
    case (size)
      SIZE_WORD: r = w;
      SIZE_HALF: r = (w >> sh) & HALF_MASK;
      default:   r = (w >> sh) & BYTE_MASK;
    endcase
    return r;
  endfunction

endpackage

// File: src/dmc_front.sv
// ----------------------------------------------------------------------------
// dmc_front
// Accepts requests, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module dmc_front
  import dmc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  back_stat_t        bstat,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              command,
  input  logic              port,
  input  logic [ADDR_W-1:0] address,
  input  logic [1:0]        size,
  input  logic [DATA_W-1:0] write_data,
  output logic              q_valid,
  output item_t             q_head,
  input  logic              pop
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  item_t      cls;
  logic       push;

  always_comb begin
    cls.cmd = command;
    cls.use_data = !port || cfg.unified;
    cls.bad = misaligned(address[1:0], size);
    cls.off = address[1:0];
    cls.size = size;
    cls.wa = address[ADDR_W-1:2];
    cls.wdata = write_data;
    if (!cfg.cache_on) begin
      cls.kind = KIND_BYPASS;
    end else if (cls.use_data) begin
      cls.kind = KIND_DATA;
    end else if (size != SIZE_WORD) begin
      cls.kind = KIND_REJECT;
    end else begin
      cls.kind = KIND_INST;
    end
  end

  assign in_ready = (count != 2'd2) && !bstat.clearing;
  assign push = in_valid && in_ready;
  assign q_valid = (count != 2'd0);
  assign q_head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= cls;
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: src/dmc_back.sv
// ----------------------------------------------------------------------------
// dmc_back
// Sequencer that carries out one request on the caches, the write buffer
// and the backing memory, and holds the result register.
// ----------------------------------------------------------------------------
module dmc_back
  import dmc_pkg::*;
#(
  parameter int LINE_WORDS = DEF_LINE_WORDS,
  parameter int DATA_CACHE_WORDS = DEF_DATA_CACHE_WORDS,
  parameter int INST_CACHE_WORDS = DEF_INST_CACHE_WORDS,
  parameter int MEMORY_WORDS = DEF_MEMORY_WORDS
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  output back_stat_t        bstat,
  input  logic              q_valid,
  input  item_t             q_head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] read_data,
  output logic              hit,
  output logic [1:0]        status,
  output logic [DATA_W-1:0] hit_count,
  output logic [DATA_W-1:0] miss_count
);

  localparam int LWB = $clog2(LINE_WORDS);
  localparam int LIW = max1(LWB);
  localparam int LNW = WA_W - LWB;
  localparam int DL = DATA_CACHE_WORDS / LINE_WORDS;
  localparam int IL = INST_CACHE_WORDS / LINE_WORDS;
  localparam int DIW = max1($clog2(DL));
  localparam int IIW = max1($clog2(IL));
  localparam int DSW = max1($clog2(DATA_CACHE_WORDS));
  localparam int ISW = max1($clog2(INST_CACHE_WORDS));
  localparam int MAW = $clog2(MEMORY_WORDS);

  state_t state;
  state_t state_next;
  item_t  cur;

  logic [DATA_W-1:0] bmem [MEMORY_WORDS];
  logic [DATA_W-1:0] dwords [DATA_CACHE_WORDS];
  logic [DATA_W-1:0] iwords [INST_CACHE_WORDS];
  logic [LNW-1:0]    dtag [DL];
  logic [LNW-1:0]    itag [IL];
  logic [DATA_W-1:0] buf_words [LINE_WORDS];

  logic [DATA_W-1:0] bq, dq, iq;
  logic [LNW-1:0]    dtag_q, itag_q;

  logic [DL-1:0]     dval, ddirty;
  logic [IL-1:0]     ival;
  logic              buf_full;
  logic [LNW-1:0]    bufln, vict_ln;
  logic [LIW-1:0]    cnt;
  logic [MAW-1:0]    clr;
  logic              hitr;
  logic [DATA_W-1:0] dh, dm, ih, im;

  logic [LNW-1:0] ln;
  logic [LIW-1:0] li;
  logic [DIW-1:0] d_idx;
  logic [IIW-1:0] i_idx;
  logic [DSW-1:0] d_slot, d_cslot;
  logic [ISW-1:0] i_slot, i_cslot;
  logic [MAW-1:0] mi, fill_addr, drain_addr;
  logic           last, isd, h;

  logic           b_we, d_we, i_we;
  logic [MAW-1:0] b_wa, b_ra;
  logic [DATA_W-1:0] b_wd, d_wd, i_wd;
  logic [DSW-1:0] d_wa, d_ra;
  logic [ISW-1:0] i_wa;
  logic           tag_we;

  assign ln = LNW'(cur.wa >> LWB);
  assign li = LIW'(cur.wa & WA_W'(LINE_WORDS - 1));
  assign d_idx = DIW'(ln & LNW'(DL - 1));
  assign i_idx = IIW'(ln & LNW'(IL - 1));
  assign d_slot = DSW'((32'(d_idx) << LWB) | 32'(li));
  assign d_cslot = DSW'((32'(d_idx) << LWB) | 32'(cnt));
  assign i_slot = ISW'((32'(i_idx) << LWB) | 32'(li));
  assign i_cslot = ISW'((32'(i_idx) << LWB) | 32'(cnt));
  assign mi = MAW'(cur.wa);
  assign fill_addr = MAW'((32'(ln) << LWB) | 32'(cnt));
  assign drain_addr = MAW'((32'(bufln) << LWB) | 32'(cnt));
  assign last = (cnt == LIW'(LINE_WORDS - 1));
  assign isd = (cur.kind == KIND_DATA);
  assign h = isd ? (dval[d_idx] && dtag_q == ln) : (ival[i_idx] && itag_q == ln);

  assign pop = (state == ST_IDLE) && q_valid && !out_valid;
  assign bstat.clearing = (state == ST_CLEAR);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr == {MAW{1'b1}}) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop) begin
          unique case (q_head.kind)
            KIND_BYPASS: state_next = ST_BP_RD;
            KIND_DATA:   state_next = buf_full ? ST_DRAIN : ST_TAG;
            KIND_INST:   state_next = ST_TAG;
            KIND_REJECT: state_next = ST_IDLE;
          endcase
        end
      end
      ST_DRAIN: begin
        if (last) begin
          state_next = ST_TAG;
        end
      end
      ST_TAG: state_next = ST_CMP;
      ST_CMP: begin
        if (isd && !h && !cfg.thru_mode && dval[d_idx] && ddirty[d_idx]) begin
          state_next = ST_EV_RD;
        end else if (cur.cmd && !cur.bad && (!isd || cfg.thru_mode)) begin
          state_next = ST_MW_RD;
        end else if (!h) begin
          state_next = ST_FL_RD;
        end else begin
          state_next = ST_CW_RD;
        end
      end
      ST_EV_RD: state_next = ST_EV_WR;
      ST_EV_WR: state_next = last ? ST_FL_RD : ST_EV_RD;
      ST_MW_RD: state_next = ST_MW_WR;
      ST_MW_WR: state_next = hitr ? ST_CW_RD : ST_FL_RD;
      ST_FL_RD: state_next = ST_FL_WR;
      ST_FL_WR: state_next = last ? ST_CW_RD : ST_FL_RD;
      ST_CW_RD: state_next = ST_CW_ACT;
      ST_CW_ACT: state_next = ST_IDLE;
      ST_BP_RD: state_next = ST_BP_ACT;
      ST_BP_ACT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    b_we = 1'b0;
    b_wa = mi;
    b_wd = merge_in(bq, cur.wdata, cur.off, cur.size);
    b_ra = (state == ST_FL_RD) ? fill_addr : mi;
    d_we = 1'b0;
    d_wa = d_slot;
    d_wd = merge_in(dq, cur.wdata, cur.off, cur.size);
    d_ra = (state == ST_EV_RD) ? d_cslot : d_slot;
    i_we = 1'b0;
    i_wa = i_slot;
    i_wd = cur.wdata;
    tag_we = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        b_we = 1'b1;
        b_wa = clr;
        b_wd = '0;
      end
      ST_DRAIN: begin
        b_we = 1'b1;
        b_wa = drain_addr;
        b_wd = buf_words[cnt];
      end
      ST_MW_WR: b_we = 1'b1;
      ST_BP_ACT: b_we = cur.cmd && !cur.bad;
      ST_FL_WR: begin
        d_we = isd;
        d_wa = d_cslot;
        d_wd = bq;
        i_we = !isd;
        i_wa = i_cslot;
        i_wd = bq;
        tag_we = last;
      end
      ST_CW_ACT: begin
        d_we = isd && cur.cmd && !cur.bad;
        i_we = !isd && cur.cmd && !cur.bad;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      bmem[b_wa] <= b_wd;
    end
    bq <= bmem[b_ra];
  end

  always_ff @(posedge clk) begin
    if (d_we) begin
      dwords[d_wa] <= d_wd;
    end
    dq <= dwords[d_ra];
  end

  always_ff @(posedge clk) begin
    if (i_we) begin
      iwords[i_wa] <= i_wd;
    end
    iq <= iwords[i_slot];
  end

  always_ff @(posedge clk) begin
    if (tag_we && isd) begin
      dtag[d_idx] <= ln;
    end
    dtag_q <= dtag[d_idx];
  end

  always_ff @(posedge clk) begin
    if (tag_we && !isd) begin
      itag[i_idx] <= ln;
    end
    itag_q <= itag[i_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr <= '0;
      cnt <= '0;
      dval <= '0;
      ddirty <= '0;
      ival <= '0;
      buf_full <= 1'b0;
      bufln <= '0;
      dh <= '0;
      dm <= '0;
      ih <= '0;
      im <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: clr <= clr + 1'b1;
        ST_IDLE: begin
          if (pop) begin
            cur <= q_head;
            cnt <= '0;
            if (q_head.kind == KIND_REJECT) begin
              out_valid <= 1'b1;
              read_data <= '0;
              hit <= 1'b0;
              status <= STATUS_NOT_WORD;
              hit_count <= ih;
              miss_count <= im;
            end
          end
        end
        ST_DRAIN: begin
          cnt <= cnt + 1'b1;
          if (last) begin
            cnt <= '0;
            buf_full <= 1'b0;
          end
        end
        ST_CMP: begin
          hitr <= h;
          vict_ln <= dtag_q;
          if (isd) begin
            if (h) dh <= dh + 1'b1;
            else dm <= dm + 1'b1;
          end else begin
            if (h) ih <= ih + 1'b1;
            else im <= im + 1'b1;
          end
        end
        ST_EV_WR: begin
          buf_words[cnt] <= dq;
          cnt <= cnt + 1'b1;
          if (last) begin
            cnt <= '0;
            bufln <= vict_ln;
            buf_full <= 1'b1;
          end
        end
        ST_FL_WR: begin
          cnt <= cnt + 1'b1;
          if (last) begin
            cnt <= '0;
            if (isd) begin
              dval[d_idx] <= 1'b1;
              if (!cur.cmd && !cfg.thru_mode) begin
                ddirty[d_idx] <= 1'b0;
              end
            end else begin
              ival[i_idx] <= 1'b1;
            end
          end
        end
        ST_CW_ACT: begin
          if (isd && cur.cmd && !cfg.thru_mode) begin
            ddirty[d_idx] <= 1'b1;
          end
          out_valid <= 1'b1;
          read_data <= (cur.cmd || cur.bad) ? '0 :
                       (isd ? take_out(dq, cur.off, cur.size) : iq);
          hit <= hitr;
          status <= cur.bad ? STATUS_MISALIGNED : STATUS_OK;
          hit_count <= isd ? dh : ih;
          miss_count <= isd ? dm : im;
        end
        ST_BP_ACT: begin
          out_valid <= 1'b1;
          read_data <= (cur.cmd || cur.bad) ? '0 : take_out(bq, cur.off, cur.size);
          hit <= 1'b0;
          status <= cur.bad ? STATUS_MISALIGNED : STATUS_OK;
          hit_count <= cur.use_data ? dh : ih;
          miss_count <= cur.use_data ? dm : im;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: src/direct_mapped_cache_with_write_buffer.sv
// ----------------------------------------------------------------------------
// direct_mapped_cache_with_write_buffer
// Direct-mapped data and instruction caches with a one-line write buffer.
// ----------------------------------------------------------------------------
// A request enters on the in channel (valid/ready) and its single result
// leaves on the out channel. Requests are queued two deep, so the block takes
// new requests while a result waits to be taken. The back end works on one
// request at a time; every step is bounded by the single port of the backing
// memory and the registered reads of the cache arrays.
// A rejected instruction access is answered from the queue; a bypass uses
// the memory directly; a hit reads tag and data; a miss adds a line refill,
// a dirty eviction copies the victim line into the buffer, a buffer drain
// writes it back, a write-through or instruction write adds a memory write.
// After reset the backing memory is cleared, one word a cycle; no request
// is taken then, though the register port works. If the receiver stalls,
// the result is held and at most two more requests are queued before
// in_ready drops.
// Registers: 0 cache_on, 1 unified, 2 thru_mode, at byte address 4*i.
// ----------------------------------------------------------------------------
module direct_mapped_cache_with_write_buffer
  import dmc_pkg::*;
#(
  parameter int LINE_WORDS = DEF_LINE_WORDS,
  parameter int DATA_CACHE_WORDS = DEF_DATA_CACHE_WORDS,
  parameter int INST_CACHE_WORDS = DEF_INST_CACHE_WORDS,
  parameter int MEMORY_WORDS = DEF_MEMORY_WORDS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              command,
  input  logic              port,
  input  logic [ADDR_W-1:0] address,
  input  logic [1:0]        size,
  input  logic [DATA_W-1:0] write_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] read_data,
  output logic              hit,
  output logic [1:0]        status,
  output logic [DATA_W-1:0] hit_count,
  output logic [DATA_W-1:0] miss_count
);

  cfg_t       cfg;
  back_stat_t bstat;
  item_t      q_head;
  logic       q_valid;
  logic       pop;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cache_on <= 1'b1;
      cfg.unified <= 1'b0;
      cfg.thru_mode <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_CACHE_ON:  cfg.cache_on <= pwdata[0];
        REG_UNIFIED:   cfg.unified <= pwdata[0];
        REG_THRU_MODE: cfg.thru_mode <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_CACHE_ON:  prdata[0] = cfg.cache_on;
      REG_UNIFIED:   prdata[0] = cfg.unified;
      REG_THRU_MODE: prdata[0] = cfg.thru_mode;
      default:       prdata = '0;
    endcase
  end

  dmc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .bstat      (bstat),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .port       (port),
    .address    (address),
    .size       (size),
    .write_data (write_data),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .pop        (pop)
  );

  dmc_back #(
    .LINE_WORDS       (LINE_WORDS),
    .DATA_CACHE_WORDS (DATA_CACHE_WORDS),
    .INST_CACHE_WORDS (INST_CACHE_WORDS),
    .MEMORY_WORDS     (MEMORY_WORDS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .bstat      (bstat),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_data  (read_data),
    .hit        (hit),
    .status     (status),
    .hit_count  (hit_count),
    .miss_count (miss_count)
  );

endmodule

// File: tb/dmc_checker.sv
// ----------------------------------------------------------------------------
// dmc_checker
// Watches the register port and both request channels of the cache block,
// keeps its own model of the caches, write buffer and memory, and compares
// every result with the oldest prediction.
// ----------------------------------------------------------------------------
module dmc_checker
  import dmc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              command,
  input  logic              port,
  input  logic [ADDR_W-1:0] address,
  input  logic [1:0]        size,
  input  logic [DATA_W-1:0] write_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [DATA_W-1:0] read_data,
  input  logic              hit,
  input  logic [1:0]        status,
  input  logic [DATA_W-1:0] hit_count,
  input  logic [DATA_W-1:0] miss_count,
  output int                errors,
  output int                outstanding,
  output int                hits_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LW = DEF_LINE_WORDS;
  localparam int DLINES = DEF_DATA_CACHE_WORDS / DEF_LINE_WORDS;
  localparam int ILINES = DEF_INST_CACHE_WORDS / DEF_LINE_WORDS;
  localparam int MWORDS = DEF_MEMORY_WORDS;

  typedef struct packed {
    logic [31:0] rdata;
    logic        hit;
    logic [1:0]  status;
    logic [31:0] hits;
    logic [31:0] misses;
  } outcome_t;

  cfg_t        cfg;
  logic [3:0]  dtag [DLINES];
  logic        dval [DLINES];
  logic        ddirty [DLINES];
  logic [31:0] dword [DLINES*LW];
  logic [3:0]  itag [ILINES];
  logic        ival [ILINES];
  logic [31:0] iword [ILINES*LW];
  logic [31:0] mem [MWORDS];
  logic [31:0] wbuf [LW];
  logic [9:0]  wbuf_line;
  logic        wbuf_full;
  logic [31:0] dhits, dmisses, ihits, imisses;
  outcome_t    expected_q [$];

  function automatic logic [31:0] lane_write(logic [31:0] old, logic [31:0] val,
                                             logic [1:0] off, logic [1:0] sz);
    logic [31:0] r;
    r = old;
    if (sz == SIZE_WORD) begin
      r = val;
    end else if (sz == SIZE_HALF) begin
      r[off*8 +: 16] = val[15:0];
    end else begin
      r[off*8 +: 8] = val[7:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] lane_read(logic [31:0] w, logic [1:0] off, logic [1:0] sz);
    if (sz == SIZE_WORD) return w;
    if (sz == SIZE_HALF) return {16'd0, w[off*8 +: 16]};
    return {24'd0, w[off*8 +: 8]};
  endfunction

  function automatic void reset_model();
    cfg = '{cache_on: 1'b1, unified: 1'b0, thru_mode: 1'b0};
    foreach (dtag[i]) begin
      dtag[i] = '0; dval[i] = 1'b0; ddirty[i] = 1'b0;
    end
    foreach (itag[i]) begin
      itag[i] = '0; ival[i] = 1'b0;
    end
    foreach (mem[i]) mem[i] = '0;
    wbuf_line = '0;
    wbuf_full = 1'b0;
    dhits = '0; dmisses = '0; ihits = '0; imisses = '0;
  endfunction

  function automatic void load_line(logic is_inst, int idx, int ln);
    for (int i = 0; i < LW; i++) begin
      if (is_inst) iword[idx*LW+i] = mem[(ln*LW+i) % MWORDS];
      else dword[idx*LW+i] = mem[(ln*LW+i) % MWORDS];
    end
  endfunction

  function automatic outcome_t access_result(logic cmd, logic prt, logic [13:0] addr,
                                             logic [1:0] sz, logic [31:0] wd);
    outcome_t o;
    logic [1:0] off;
    int wa, ln, li, mi, idx, slot;
    logic [3:0] tg;
    logic bad, to_data, hv;
    off = addr[1:0];
    wa = int'(addr >> 2);
    ln = wa / LW;
    li = wa % LW;
    mi = wa % MWORDS;
    case (sz)
      SIZE_WORD: bad = (off != 2'd0);
      SIZE_HALF: bad = off[0];
      SIZE_BYTE: bad = 1'b0;
      default:   bad = 1'b1;
    endcase
    to_data = !prt || cfg.unified;
    o = '0;
    o.status = bad ? STATUS_MISALIGNED : STATUS_OK;
    if (!cfg.cache_on) begin
      if (!bad) begin
        if (cmd) mem[mi] = lane_write(mem[mi], wd, off, sz);
        else o.rdata = lane_read(mem[mi], off, sz);
      end
    end else if (to_data) begin
      idx = ln % DLINES;
      tg = 4'(ln / DLINES);
      slot = idx*LW + li;
      if (wbuf_full) begin
        for (int i = 0; i < LW; i++) mem[(wbuf_line*LW+i) % MWORDS] = wbuf[i];
        wbuf_full = 1'b0;
      end
      hv = dval[idx] && dtag[idx] == tg;
      o.hit = hv;
      if (hv) dhits++; else dmisses++;
      if (!hv && !cfg.thru_mode && dval[idx] && ddirty[idx]) begin
        for (int i = 0; i < LW; i++) wbuf[i] = dword[idx*LW+i];
        wbuf_line = 10'(dtag[idx]*DLINES + idx);
        wbuf_full = 1'b1;
      end
      if (cmd && cfg.thru_mode && !bad) mem[mi] = lane_write(mem[mi], wd, off, sz);
      if (!hv) begin
        load_line(1'b0, idx, ln);
        dtag[idx] = tg;
        dval[idx] = 1'b1;
        if (!cmd && !cfg.thru_mode) ddirty[idx] = 1'b0;
      end
      if (!cmd) begin
        if (!bad) o.rdata = lane_read(dword[slot], off, sz);
      end else begin
        if (!bad) dword[slot] = lane_write(dword[slot], wd, off, sz);
        if (!cfg.thru_mode) ddirty[idx] = 1'b1;
      end
    end else if (sz != SIZE_WORD) begin
      o.status = STATUS_NOT_WORD;
    end else begin
      idx = ln % ILINES;
      tg = 4'(ln / ILINES);
      slot = idx*LW + li;
      hv = ival[idx] && itag[idx] == tg;
      o.hit = hv;
      if (hv) ihits++; else imisses++;
      if (cmd && !bad) mem[mi] = wd;
      if (!hv) begin
        load_line(1'b1, idx, ln);
        itag[idx] = tg;
        ival[idx] = 1'b1;
      end else if (cmd && !bad) begin
        iword[slot] = wd;
      end
      if (!cmd && !bad) o.rdata = iword[slot];
    end
    o.hits = to_data ? dhits : ihits;
    o.misses = to_data ? dmisses : imisses;
    if (cmd || o.status != STATUS_OK) o.rdata = '0;
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t e;
    int       fails;
    fails = 0;
    if (rst) begin
      reset_model();
      expected_q.delete();
      errors <= 0;
      hits_seen <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_CACHE_ON:  cfg.cache_on = pwdata[0];
          REG_UNIFIED:   cfg.unified = pwdata[0];
          REG_THRU_MODE: cfg.thru_mode = pwdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_q.push_back(access_result(command, port, address, size, write_data));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding");
          fails++;
        end else begin
          e = expected_q.pop_front();
          if (hit) hits_seen <= hits_seen + 1;
          if (read_data !== e.rdata) begin
            $error("read_data expected %h actual %h", e.rdata, read_data);
            fails++;
          end
          if (hit !== e.hit) begin
            $error("hit expected %0d actual %0d", e.hit, hit);
            fails++;
          end
          if (status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, status);
            fails++;
          end
          if (hit_count !== e.hits) begin
            $error("hit_count expected %0d actual %0d", e.hits, hit_count);
            fails++;
          end
          if (miss_count !== e.misses) begin
            $error("miss_count expected %0d actual %0d", e.misses, miss_count);
            fails++;
          end
        end
      end
      if (fails != 0) errors <= errors + fails;
    end
    outstanding <= expected_q.size();
  end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives requests and register writes into the cache block under several
// cache settings and handshake pressure; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top
  import dmc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic              clk = 0;
  logic              rst = 1;
  logic              psel = 0, penable = 0, pwrite = 0;
  logic [3:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid = 0;
  logic              in_ready;
  logic              command = 0, port = 0;
  logic [ADDR_W-1:0] address = '0;
  logic [1:0]        size = '0;
  logic [DATA_W-1:0] write_data = '0;
  logic              out_valid;
  logic              out_ready = 0;
  logic [DATA_W-1:0] read_data, hit_count, miss_count;
  logic              hit;
  logic [1:0]        status;
  int                errors, outstanding, hits_seen;
  int                send_idle = 6, recv_idle = 56;
  bit                hold_long = 0;
  int                requests_sent = 0;

  always #2 clk = ~clk;

  direct_mapped_cache_with_write_buffer DUT (.*);
  dmc_checker checker_i (.*);

  task automatic reg_write(logic [1:0] idx, logic v);
    @(posedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= {31'd0, v};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic set_mode(logic en, logic uni, logic wt);
    reg_write(REG_CACHE_ON, en);
    reg_write(REG_UNIFIED, uni);
    reg_write(REG_THRU_MODE, wt);
  endtask

  task automatic send(logic c, logic p, logic [13:0] a, logic [1:0] s, logic [31:0] d);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1; command <= c; port <= p; address <= a; size <= s; write_data <= d;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  task automatic send_random();
    logic [13:0] a;
    logic [1:0]  s;
    if ($urandom_range(99) < 15) begin
      send(1'($urandom_range(1)), 1'($urandom_range(1)), 14'($urandom_range(16383)),
           2'($urandom_range(3)), $urandom);
    end else begin
      s = ($urandom_range(99) < 4) ? SIZE_INVALID : 2'($urandom_range(2));
      a = {4'($urandom_range(2)), 2'($urandom_range(1)), 4'($urandom_range(5)),
           2'($urandom_range(3)), 2'd0};
      if ($urandom_range(99) < 10) a[1:0] = 2'($urandom_range(3));
      else if (s == SIZE_HALF) a[1] = 1'($urandom_range(1));
      else if (s == SIZE_BYTE) a[1:0] = 2'($urandom_range(3));
      send($urandom_range(99) < 40, $urandom_range(99) < 25, a, s, $urandom);
    end
  endtask

  task automatic drain_all();
    in_valid <= 0;
    do @(posedge clk); while (outstanding != 0);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_ready <= 0;
        repeat (300) @(posedge clk);
        hold_long = 0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin
    logic [2:0] modes [8];
    modes = '{3'b100, 3'b101, 3'b110, 3'b111, 3'b000, 3'b011, 3'b100, 3'b110};
    repeat (10) @(posedge clk);
    rst <= 0;
    set_mode(1, 0, 0);
    send(0, 0, 14'h0000, SIZE_WORD, 32'h0);
    send(1, 0, 14'h0000, SIZE_WORD, 32'hFFFF_FFFF);
    send(0, 0, 14'h0000, SIZE_WORD, 32'h0);
    send(1, 0, 14'h0006, SIZE_HALF, 32'h1234_ABCD);
    send(0, 0, 14'h0006, SIZE_HALF, 32'h0);
    send(1, 0, 14'h0001, SIZE_BYTE, 32'h0000_005A);
    send(0, 0, 14'h0003, SIZE_BYTE, 32'h0);
    send(0, 0, 14'h0001, SIZE_WORD, 32'h0);
    send(1, 0, 14'h0005, SIZE_HALF, 32'hDEAD_BEEF);
    send(0, 0, 14'h0004, SIZE_INVALID, 32'h0);
    send(1, 0, 14'h0400, SIZE_WORD, 32'h8765_4321);
    send(0, 0, 14'h0000, SIZE_WORD, 32'h0);
    send(0, 0, 14'h0400, SIZE_WORD, 32'h0);
    send(1, 1, 14'h0800, SIZE_WORD, 32'hCAFE_F00D);
    send(0, 1, 14'h0800, SIZE_WORD, 32'h0);
    send(0, 1, 14'h0802, SIZE_HALF, 32'h0);
    send(1, 1, 14'h0801, SIZE_WORD, 32'h1);
    send(1, 0, 14'h3FFF, SIZE_BYTE, 32'hFFFF_FFFF);
    send(0, 0, 14'h3FFC, SIZE_WORD, 32'h0);
    send(0, 1, 14'h3FFC, SIZE_WORD, 32'h0);
    drain_all();
    for (int ph = 0; ph < 8; ph++) begin
      send_idle = (ph < 3) ? 6 : (ph < 6) ? 56 : 0;
      recv_idle = (ph < 3) ? 56 : (ph < 6) ? 6 : 0;
      set_mode(modes[ph][2], modes[ph][1], modes[ph][0]);
      for (int n = 0; n < 125; n++) begin
        if (ph == 1 && n == 40) hold_long = 1;
        send_random();
      end
      drain_all();
    end
    $display("Sent %0d requests over eight cache settings; %0d results were hits.",
             requests_sent, hits_seen);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
